/* design/sha1_pkg.sv */
// Shared types and constants for the SHA-1 engine.
// No dependencies; used by sha1_round and sha1_hash_engine.
package sha1_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned NumWords = 5;
    localparam int unsigned WinWords = 16;
    localparam int unsigned Rounds   = 80;
    localparam int unsigned WinBits  = WordW * WinWords;

    // Chaining initial values, index 0 is h0
    localparam logic [NumWords-1:0][WordW-1:0] ChainInit = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WordW-1:0] K0 = 32'h5A827999;
    localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PadMark   = 8'h80;
    localparam logic [5:0] LenStart  = 6'd56;
    localparam logic [5:0] LastPos   = 6'd63;
    localparam logic [2:0] LastIndex = 3'd4;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KICK,
        ST_WAIT,
        ST_PAD,
        ST_SEND
    } top_state_t;

    // Round unit sequencer
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_FOLD
    } core_state_t;

    // Commands from the top sequencer to the round unit
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       start;
        logic       chain_init;
    } sha1_ctl_t;

    // Round function for round t
    function automatic logic [WordW-1:0] round_f(
        input logic [6:0]       t,
        input logic [WordW-1:0] b,
        input logic [WordW-1:0] c,
        input logic [WordW-1:0] d
    );
        logic [WordW-1:0] f;
        if (t < 7'd20)
            f = (b & c) | (~b & d);
        else if (t < 7'd40)
            f = b ^ c ^ d;
        else if (t < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

    // Round constant for round t
    function automatic logic [WordW-1:0] round_k(input logic [6:0] t);
        logic [WordW-1:0] k;
        if (t < 7'd20)
            k = K0;
        else if (t < 7'd40)
            k = K1;
        else if (t < 7'd60)
            k = K2;
        else
            k = K3;
        return k;
    endfunction

endpackage

/* design/sha1_hash_engine.sv */
// SHA-1 engine top level: byte intake, padding sequencer and digest output.
// Depends on sha1_pkg and sha1_round.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  msg     | msg_valid / msg_ready | data_byte, has_byte, end_of_message
//  dig     | dig_valid / dig_ready | digest_word, word_number, last_word
//
// Intake stays open after an item, except one that completes a 64-byte block,
// which is followed by a start step, the rounds, a fold and an idle check.
// End of message: padding is shifted in one byte a cycle up to the block end and
// compressed; a second block follows when the length does not fit. Then five
// digest words, one per accepted item.
// Reset is asynchronous and active low; it loads the initial chaining words.
// A stalled digest word holds; msg_ready stays low until the last word leaves.
module sha1_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        dig_valid,
    input  logic        dig_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);

    sha1_pkg::top_state_t state_reg, state_next;
    sha1_pkg::sha1_ctl_t  ctl;
    logic        busy;
    logic [sha1_pkg::NumWords-1:0][sha1_pkg::WordW-1:0] chain;

    logic [60:0] total_reg, total_next;
    logic [5:0]  pad_pos_reg, pad_pos_next;
    logic        first_reg, first_next;
    logic        len_zone_reg, len_zone_next;
    logic        pad_reg, pad_next;
    logic        final_reg, final_next;
    logic        eom_pend_reg, eom_pend_next;
    logic [2:0]  idx_reg, idx_next;

    logic        msg_take, dig_take;
    logic        len_eff;
    logic [63:0] bit_len, len_shift;
    logic [7:0]  pad_byte;

    assign msg_take = msg_valid && msg_ready;
    assign dig_take = dig_valid && dig_ready;

    // Padding byte: marker, zeros, then the big-endian bit length
    assign bit_len   = {total_reg, 3'b000};
    assign len_shift = bit_len << {pad_pos_reg[2:0], 3'b000};
    assign len_eff   = first_reg ? (pad_pos_reg < sha1_pkg::LenStart) : len_zone_reg;
    always_comb
    begin
        if (first_reg)
            pad_byte = sha1_pkg::PadMark;
        else if (len_eff && pad_pos_reg >= sha1_pkg::LenStart)
            pad_byte = len_shift[63:56];
        else
            pad_byte = 8'h00;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (msg_take)
                begin
                    if (has_byte && total_reg[5:0] == sha1_pkg::LastPos)
                        state_next = sha1_pkg::ST_KICK;
                    else if (end_of_message)
                        state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_KICK:
                state_next = sha1_pkg::ST_WAIT;
            sha1_pkg::ST_WAIT:
            begin
                if (!busy)
                begin
                    if (final_reg)
                        state_next = sha1_pkg::ST_SEND;
                    else if (pad_reg || eom_pend_reg)
                        state_next = sha1_pkg::ST_PAD;
                    else
                        state_next = sha1_pkg::ST_IDLE;
                end
            end
            sha1_pkg::ST_PAD:
            begin
                if (pad_pos_reg == sha1_pkg::LastPos)
                    state_next = sha1_pkg::ST_KICK;
            end
            sha1_pkg::ST_SEND:
            begin
                if (dig_take && idx_reg == sha1_pkg::LastIndex)
                    state_next = sha1_pkg::ST_IDLE;
            end
            default:
                state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs and round unit commands
    always_comb
    begin
        msg_ready      = (state_reg == sha1_pkg::ST_IDLE);
        dig_valid      = (state_reg == sha1_pkg::ST_SEND);
        ctl.shift_byte = 1'b0;
        ctl.byte_val   = data_byte;
        ctl.start      = 1'b0;
        ctl.chain_init = 1'b0;
        case (state_reg)
            sha1_pkg::ST_IDLE:
                ctl.shift_byte = msg_take && has_byte;
            sha1_pkg::ST_KICK:
                ctl.start = 1'b1;
            sha1_pkg::ST_PAD:
            begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = pad_byte;
            end
            sha1_pkg::ST_SEND:
                ctl.chain_init = dig_take && idx_reg == sha1_pkg::LastIndex;
            default:
                ctl.start = 1'b0;
        endcase
    end

    // Counters and flags
    always_comb
    begin
        total_next    = total_reg;
        pad_pos_next  = pad_pos_reg;
        first_next    = first_reg;
        len_zone_next = len_zone_reg;
        pad_next      = pad_reg;
        final_next    = final_reg;
        eom_pend_next = eom_pend_reg;
        idx_next      = idx_reg;
        case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (msg_take)
                begin
                    if (has_byte)
                        total_next = total_reg + 61'd1;
                    eom_pend_next = end_of_message;
                    pad_next      = 1'b0;
                    final_next    = 1'b0;
                    first_next    = 1'b1;
                    pad_pos_next  = total_next[5:0];
                    if (end_of_message && !(has_byte && total_reg[5:0] == sha1_pkg::LastPos))
                        pad_next = 1'b1;
                end
            end
            sha1_pkg::ST_WAIT:
            begin
                if (!busy && !final_reg && !pad_reg && eom_pend_reg)
                begin
                    pad_next     = 1'b1;
                    first_next   = 1'b1;
                    pad_pos_next = total_reg[5:0];
                end
                idx_next = 3'd0;
            end
            sha1_pkg::ST_PAD:
            begin
                pad_pos_next  = pad_pos_reg + 6'd1;
                first_next    = 1'b0;
                len_zone_next = len_eff;
                if (pad_pos_reg == sha1_pkg::LastPos)
                begin
                    final_next    = len_eff;
                    len_zone_next = 1'b1;
                end
            end
            sha1_pkg::ST_SEND:
            begin
                if (dig_take)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha1_pkg::LastIndex)
                    begin
                        total_next    = 61'd0;
                        pad_next      = 1'b0;
                        final_next    = 1'b0;
                        eom_pend_next = 1'b0;
                        idx_next      = 3'd0;
                    end
                end
            end
            default:
                idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha1_pkg::ST_IDLE;
            total_reg    <= 61'd0;
            pad_pos_reg  <= 6'd0;
            first_reg    <= 1'b0;
            len_zone_reg <= 1'b0;
            pad_reg      <= 1'b0;
            final_reg    <= 1'b0;
            eom_pend_reg <= 1'b0;
            idx_reg      <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            pad_pos_reg  <= pad_pos_next;
            first_reg    <= first_next;
            len_zone_reg <= len_zone_next;
            pad_reg      <= pad_next;
            final_reg    <= final_next;
            eom_pend_reg <= eom_pend_next;
            idx_reg      <= idx_next;
        end
    end

    sha1_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .busy  (busy),
        .chain (chain)
    );

    // Digest word straight from the chaining registers
    always_comb
    begin
        case (idx_reg)
            3'd0:    digest_word = chain[0];
            3'd1:    digest_word = chain[1];
            3'd2:    digest_word = chain[2];
            3'd3:    digest_word = chain[3];
            default: digest_word = chain[4];
        endcase
    end
    assign word_number = idx_reg;
    assign last_word   = (idx_reg == sha1_pkg::LastIndex);

    // Intake and output never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && dig_valid))
        else $error("intake and digest output both open");

    // Padding bytes never enter the window while rounds run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::ST_PAD) |-> !busy)
        else $error("padding while round unit busy");

    // After the last word leaves, intake opens at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (dig_take && last_word) |=> (msg_ready && total_reg == 61'd0))
        else $error("engine not back to idle after digest");

    // Digest index stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (word_number <= sha1_pkg::LastIndex))
        else $error("digest word index out of range");

endmodule

/* design/sha1_round.sv */
// SHA-1 round unit: 16-word schedule window, round variables, chaining words.
// One round per cycle under a small sequencer. Depends on sha1_pkg.
module sha1_round (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  sha1_pkg::sha1_ctl_t                               ctl,
    output logic                                              busy,
    output logic [sha1_pkg::NumWords-1:0][sha1_pkg::WordW-1:0] chain
);

    sha1_pkg::core_state_t state_reg, state_next;
    logic [6:0] round_reg, round_next;
    logic [sha1_pkg::WinWords-1:0][sha1_pkg::WordW-1:0] win_reg, win_next;
    logic [sha1_pkg::NumWords-1:0][sha1_pkg::WordW-1:0] vars_reg, vars_next;
    logic [sha1_pkg::NumWords-1:0][sha1_pkg::WordW-1:0] chain_reg, chain_next;
    logic [sha1_pkg::WordW-1:0] w_mix, w_cur, sum;
    logic [sha1_pkg::WordW-1:0] va, vb, vc, vd, ve;

    assign va = vars_reg[0];
    assign vb = vars_reg[1];
    assign vc = vars_reg[2];
    assign vd = vars_reg[3];
    assign ve = vars_reg[4];

    // Schedule word: oldest word sits at the top of the window
    assign w_mix = win_reg[2] ^ win_reg[7] ^ win_reg[13] ^ win_reg[15];
    assign w_cur = (round_reg < 7'd16) ? win_reg[15] : {w_mix[30:0], w_mix[31]};

    // One five-operand add per round
    assign sum = {va[26:0], va[31:27]} + sha1_pkg::round_f(round_reg, vb, vc, vd)
               + ve + sha1_pkg::round_k(round_reg) + w_cur;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1_pkg::CS_IDLE:
            begin
                if (ctl.start)
                    state_next = sha1_pkg::CS_ROUND;
            end
            sha1_pkg::CS_ROUND:
            begin
                if (round_reg == 7'(sha1_pkg::Rounds - 1))
                    state_next = sha1_pkg::CS_FOLD;
            end
            sha1_pkg::CS_FOLD:
                state_next = sha1_pkg::CS_IDLE;
            default:
                state_next = sha1_pkg::CS_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        round_next = round_reg;
        win_next   = win_reg;
        vars_next  = vars_reg;
        chain_next = chain_reg;
        busy       = (state_reg != sha1_pkg::CS_IDLE);
        case (state_reg)
            sha1_pkg::CS_IDLE:
            begin
                if (ctl.shift_byte)
                    win_next = sha1_pkg::WinBits'({win_reg, ctl.byte_val});
                if (ctl.chain_init)
                    chain_next = sha1_pkg::ChainInit;
                if (ctl.start)
                begin
                    vars_next  = chain_reg;
                    round_next = 7'd0;
                end
            end
            sha1_pkg::CS_ROUND:
            begin
                win_next     = {win_reg[sha1_pkg::WinWords-2:0], w_cur};
                vars_next[0] = sum;
                vars_next[1] = va;
                vars_next[2] = {vb[1:0], vb[31:2]};
                vars_next[3] = vc;
                vars_next[4] = vd;
                round_next   = round_reg + 7'd1;
            end
            sha1_pkg::CS_FOLD:
            begin
                for (int i = 0; i < sha1_pkg::NumWords; i++)
                    chain_next[i] = chain_reg[i] + vars_reg[i];
            end
            default:
            begin
                round_next = 7'd0;
            end
        endcase
    end

    // Control state and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1_pkg::CS_IDLE;
            round_reg <= 7'd0;
            chain_reg <= sha1_pkg::ChainInit;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    // Window and round variables, no reset
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
    end

    assign chain = chain_reg;

endmodule

/* bench/tb_sha1_hash_engine.sv */
// Self-checking bench for sha1_hash_engine: random byte streams, digests predicted in a scoreboard.
// Depends on sha1_pkg and on the sha1_hash_engine RTL, which also needs sha1_round.
`timescale 1ns / 100ps

// One expected digest word as it leaves the block
typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
} digest_entry_t;

// Streaming SHA-1 predictor plus the queue of digest words still owed
class sha1_scoreboard;

    logic [31:0]   chain_state [5];
    logic [7:0]    block_buf [64];
    logic [60:0]   byte_count;
    digest_entry_t owed_words [$];
    int            mismatches;

    function new();
        for (int i = 0; i < 5; i++)
            chain_state[i] = sha1_pkg::ChainInit[i];
        for (int i = 0; i < 64; i++)
            block_buf[i] = 8'h00;
        byte_count = '0;
        mismatches = 0;
    endfunction

    // 80-round compression of block_buf into the chaining words
    function void compress();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, k, sum, x;
        for (int t = 0; t < 16; t++)
            sched[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
        a = chain_state[0];
        b = chain_state[1];
        c = chain_state[2];
        d = chain_state[3];
        e = chain_state[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                x = sched[(t-3)%16] ^ sched[(t-8)%16] ^ sched[(t-14)%16] ^ sched[t%16];
                sched[t%16] = {x[30:0], x[31]};
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + sched[t%16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        chain_state[0] += a;
        chain_state[1] += b;
        chain_state[2] += c;
        chain_state[3] += d;
        chain_state[4] += e;
    endfunction

    // Accepted input item: absorb the byte, and on end of message pad and queue the digest
    function void note_item(input logic [7:0] data, input logic hb, input logic eom);
        int unsigned   pos;
        logic [63:0]   bit_len;
        digest_entry_t entry;
        if (hb)
        begin
            pos = byte_count[5:0];
            block_buf[pos] = data;
            byte_count++;
            if (pos == sha1_pkg::LastPos)
                compress();
        end
        if (!eom)
            return;
        pos = byte_count[5:0];
        block_buf[pos] = sha1_pkg::PadMark;
        for (int i = pos + 1; i < 64; i++)
            block_buf[i] = 8'h00;
        // no room left for the length: it goes into an extra block
        if (pos >= sha1_pkg::LenStart)
        begin
            compress();
            for (int i = 0; i < 56; i++)
                block_buf[i] = 8'h00;
        end
        bit_len = {byte_count, 3'b000};
        for (int i = 0; i < 8; i++)
            block_buf[56+i] = bit_len[63-8*i -: 8];
        compress();
        for (int i = 0; i < 5; i++)
        begin
            entry = '{chain_state[i], 3'(i), (3'(i) == sha1_pkg::LastIndex)};
            owed_words = {owed_words, entry};
        end
        for (int i = 0; i < 5; i++)
            chain_state[i] = sha1_pkg::ChainInit[i];
        byte_count = '0;
    endfunction

    task report(input string msg);
        mismatches++;
        $display("%0t MISMATCH: %s", $realtime, msg);
    endtask

    // Accepted digest word against the oldest owed one
    task check_word(input logic [31:0] word, input logic [2:0] index, input logic last);
        digest_entry_t owed;
        if (owed_words.size() == 0)
        begin
            report($sformatf("digest word %h (index %0d) with none owed", word, index));
            return;
        end
        owed = owed_words.pop_front();
        if (word !== owed.word)
            report($sformatf("digest_word %h, predicted %h", word, owed.word));
        if (index !== owed.index)
            report($sformatf("word_number %0d, predicted %0d", index, owed.index));
        if (last !== owed.last)
            report($sformatf("last_word %b, predicted %b", last, owed.last));
    endtask

    function int owed_count();
        return owed_words.size();
    endfunction

endclass

module tb_sha1_hash_engine;

    localparam int CycleLimit = 300000;

    logic        clk;
    logic        rst_n;
    logic        msg_valid;
    logic        msg_ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_message;
    logic        dig_valid;
    logic        dig_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    sha1_scoreboard sb = new();

    int burst_left = 0;
    int hold_request = 0;
    int items_sent = 0;
    int messages_sent = 0;
    int cycle_count = 0;

    sha1_hash_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_ready      (msg_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .dig_valid      (dig_valid),
        .dig_ready      (dig_ready),
        .digest_word    (digest_word),
        .word_number    (word_number),
        .last_word      (last_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one item, idling first when the current burst is used up
    task automatic offer(input logic [7:0] data, input logic hb, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        msg_valid      <= 1'b1;
        data_byte      <= data;
        has_byte       <= hb;
        end_of_message <= eom;
        @(posedge clk);
        while (!msg_ready)
            @(posedge clk);
        sb.note_item(data, hb, eom);
        items_sent++;
        if (eom)
            messages_sent++;
    endtask

    // One message of len random bytes; the end flag rides on the last byte or on an empty item
    task automatic send_message(input int len, input bit eom_on_byte, input int noise_pct);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (i == len - 1));
        end
        if (!eom_on_byte || len == 0)
            offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Sender stands still until every owed digest word has come out
    task automatic drain();
        msg_valid <= 1'b0;
        while (sb.owed_count() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int len;
        rst_n          = 1'b0;
        msg_valid      = 1'b0;
        data_byte      = 8'h00;
        has_byte       = 1'b0;
        end_of_message = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, "abc", ignored items, extreme bytes, back-to-back ends
        offer(8'hA5, 1'b0, 1'b1);
        offer(8'h61, 1'b1, 1'b0);
        offer(8'h62, 1'b1, 1'b0);
        offer(8'h63, 1'b1, 1'b1);
        offer(8'hFF, 1'b0, 1'b0);
        offer(8'h00, 1'b1, 1'b0);
        offer(8'h00, 1'b0, 1'b0);
        offer(8'hFF, 1'b1, 1'b0);
        offer(8'h5A, 1'b0, 1'b1);
        offer(8'h80, 1'b1, 1'b1);
        offer(8'h00, 1'b0, 1'b1);
        offer(8'hFF, 1'b0, 1'b1);
        offer(8'hFF, 1'b1, 1'b1);
        drain();

        // random messages, lengths biased towards the padding boundaries
        while (items_sent < 300)
        begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(55, 65);
                1:       len = $urandom_range(119, 129);
                2:       len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (messages_sent == 8)
            begin
                hold_request = 600;
                len = 3;
            end
            if (messages_sent == 12)
                drain();
            send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 10 : 0);
        end

        drain();
        repeat (300) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[sha1_hash_engine] OK");
        else
            $display("[sha1_hash_engine] ERROR");
        $finish;
    end

    // Digest side: check accepted words, stall in phases of random style
    initial
    begin
        int hold_left;
        int phase_left;
        int stall_mode;
        int tick;
        hold_left  = 0;
        phase_left = 0;
        stall_mode = 0;
        tick       = 0;
        dig_ready  = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (dig_valid && dig_ready)
                sb.check_word(digest_word, word_number, last_word);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                dig_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       dig_ready <= 1'b1;
                    1:       dig_ready <= ($urandom_range(0, 3) != 0);
                    default: dig_ready <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[sha1_hash_engine] ERROR");
        $finish;
    end

endmodule

/* sha1_hash_engine.f */
design/sha1_pkg.sv
design/sha1_round.sv
design/sha1_hash_engine.sv
bench/tb_sha1_hash_engine.sv
